[sv/assert_macros.svh]
// Assertion macros used by the deque top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define DQR_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define DQR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

[sv/dqr_pkg.sv]
// Types, codes and constants shared by the deque design files.
package dqr_pkg;

   localparam int DQR_DEPTH_DEF = 64;
   localparam int KEY_W         = 32;
   localparam int MODE_W        = 3;
   localparam int STATUS_W      = 3;

   // command queue between the front end and the execution engine
   localparam int CQ_DEPTH = 2;
   localparam int CQ_PTR_W = 1;
   localparam int CQ_CNT_W = 2;

   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DUMP       = 3'd4;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_DUMP
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DUMPED    = 3'd0,
      ST_POPPED    = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_POP,
      BK_DUMP
   } bk_state_type;

   typedef struct packed {
      op_type                  op;
      logic signed [KEY_W-1:0] key;
   } cmd_type;

endpackage

[sv/dqr_front.sv]
// Front end: decode the request mode into a command and drop undefined modes.
module dqr_front
   import dqr_pkg::*;
(
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic signed [KEY_W-1:0] req_key_in,
   output logic                    cq_push,
   output cmd_type                 cq_cmd,
   input  logic                    cq_full
);

   logic   mode_ok;
   op_type op;

   always_comb begin
      mode_ok = 1'b1;
      op      = OP_PUSH_FRONT;
      case (req_mode)
         MODE_PUSH_FRONT: op = OP_PUSH_FRONT;
         MODE_PUSH_BACK:  op = OP_PUSH_BACK;
         MODE_POP_FRONT:  op = OP_POP_FRONT;
         MODE_POP_BACK:   op = OP_POP_BACK;
         MODE_DUMP:       op = OP_DUMP;
         default:         mode_ok = 1'b0;
      endcase
   end

   // undefined modes are taken and dropped here
   assign req_ready  = !cq_full;
   assign cq_push    = req_valid && !cq_full && mode_ok;
   assign cq_cmd.op  = op;
   assign cq_cmd.key = req_key_in;

endmodule

[sv/dqr_cmd_queue.sv]
// Two-entry command queue between the front end and the execution engine.
module dqr_cmd_queue
   import dqr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cmd_type             push_cmd,
   output logic                full,
   input  logic                pop,
   output cmd_type             pop_cmd,
   output logic                not_empty,
   output logic [CQ_CNT_W-1:0] count
);

   logic [CQ_CNT_W-1:0] count_ff, count_in;
   logic [CQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   cmd_type             slot_ff [CQ_DEPTH];

   always_comb begin
      count_in  = count_ff + CQ_CNT_W'(push) - CQ_CNT_W'(pop);
      wr_ptr_in = push ? wr_ptr_ff + CQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + CQ_PTR_W'(1) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full      = (count_ff == CQ_CNT_W'(CQ_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

[sv/dqr_back.sv]
// Execution engine: ring store, pointers, dump sequencer and result register.
module dqr_back
   import dqr_pkg::*;
#(
   parameter int DEPTH = DQR_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cq_valid,
   input  cmd_type                       cq_cmd,
   output logic                          cq_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic signed [KEY_W-1:0]       rsp_key_out,
   output logic                          rsp_last,
   output logic [$clog2(DEPTH+1)-1:0]    occ_count
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(DEPTH);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                             input logic [IW-1:0] ofs);
      logic [IW:0] sum;
      sum = {1'b0, base} + {1'b0, ofs};
      if (sum >= DEPTH_X) sum = sum - DEPTH_X;
      return sum[IW-1:0];
   endfunction

   bk_state_type   state_ff, state_in;
   logic [IW-1:0]  front_ff, front_in;
   logic [CW-1:0]  occ_ff, occ_in;
   logic           rev_ff, rev_in;
   logic           data_vld_ff, data_vld_in;
   logic [CW-1:0]  rd_idx_ff, rd_idx_in;
   logic [CW-1:0]  out_idx_ff, out_idx_in;
   logic           out_valid_ff, out_valid_in;
   status_type     out_status_ff, out_status_in;
   logic [KEY_W-1:0] out_key_ff, out_key_in;
   logic           out_last_ff, out_last_in;
   logic [KEY_W-1:0] rd_data_ff;

   logic [KEY_W-1:0] key_mem [DEPTH];

   logic           can_load, load_now, take, occ_empty, occ_full, dump_last, head;
   logic           wr_en, rd_en, out_load;
   logic [IW-1:0]  wr_addr, rd_addr, dump_pos;
   logic [CW-1:0]  occ_m1;

   assign can_load  = !out_valid_ff || rsp_ready;
   assign load_now  = data_vld_ff && can_load;
   assign take      = (state_ff == BK_IDLE) && cq_valid && can_load;
   assign occ_empty = (occ_ff == '0);
   assign occ_full  = (occ_ff == CW'(DEPTH));
   assign occ_m1    = occ_ff - CW'(1);
   assign dump_last = (out_idx_ff == occ_m1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (take && !occ_empty && cq_cmd.op == OP_POP_BACK) begin
               state_in = BK_POP;
            end else if (take && !occ_empty && cq_cmd.op == OP_DUMP) begin
               state_in = BK_DUMP;
            end
         end
         BK_POP: begin
            if (load_now) state_in = BK_IDLE;
         end
         BK_DUMP: begin
            if (load_now && dump_last) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cq_pop        = take;
      front_in      = front_ff;
      occ_in        = occ_ff;
      rev_in        = rev_ff;
      data_vld_in   = data_vld_ff;
      rd_idx_in     = rd_idx_ff;
      out_idx_in    = out_idx_ff;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      rd_en         = 1'b0;
      rd_addr       = front_ff;
      out_load      = 1'b0;
      out_status_in = out_status_ff;
      out_key_in    = out_key_ff;
      out_last_in   = out_last_ff;
      head          = 1'b0;
      dump_pos      = rev_ff ? IW'(occ_m1 - rd_idx_ff) : rd_idx_ff[IW-1:0];
      case (state_ff)
         BK_IDLE: begin
            if (take) begin
               case (cq_cmd.op)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     head = (cq_cmd.op == OP_PUSH_FRONT) != rev_ff;
                     if (occ_full) begin
                        out_load      = 1'b1;
                        out_status_in = ST_FULL;
                        out_key_in    = '0;
                        out_last_in   = 1'b1;
                     end else begin
                        wr_en  = 1'b1;
                        occ_in = occ_ff + CW'(1);
                        if (head) begin
                           front_in = (front_ff == '0) ? LAST_IDX : front_ff - IW'(1);
                           wr_addr  = front_in;
                        end else begin
                           wr_addr = slot_of(front_ff, occ_ff[IW-1:0]);
                        end
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     head = (cq_cmd.op == OP_POP_FRONT) != rev_ff;
                     if (occ_empty) begin
                        out_load      = 1'b1;
                        out_status_in = ST_NOT_FOUND;
                        out_key_in    = '0;
                        out_last_in   = 1'b1;
                     end else begin
                        occ_in = occ_m1;
                        if (head) begin
                           rd_addr  = front_ff;
                           front_in = slot_of(front_ff, IW'(1));
                        end else begin
                           rd_addr = slot_of(front_ff, occ_m1[IW-1:0]);
                        end
                        if (cq_cmd.op == OP_POP_BACK) begin
                           rd_en       = 1'b1;
                           data_vld_in = 1'b1;
                        end
                     end
                  end
                  OP_DUMP: begin
                     rev_in = !rev_ff;
                     if (occ_empty) begin
                        out_load      = 1'b1;
                        out_status_in = ST_EMPTY;
                        out_key_in    = '0;
                        out_last_in   = 1'b1;
                     end else begin
                        rd_idx_in  = '0;
                        out_idx_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_POP: begin
            if (load_now) begin
               out_load      = 1'b1;
               out_status_in = ST_POPPED;
               out_key_in    = rd_data_ff;
               out_last_in   = 1'b1;
               data_vld_in   = 1'b0;
            end
         end
         BK_DUMP: begin
            // keep one key in flight from the store ahead of the result register
            rd_en   = (rd_idx_ff < occ_ff) && (!data_vld_ff || load_now);
            rd_addr = slot_of(front_ff, dump_pos);
            if (rd_en) begin
               rd_idx_in   = rd_idx_ff + CW'(1);
               data_vld_in = 1'b1;
            end else if (load_now) begin
               data_vld_in = 1'b0;
            end
            if (load_now) begin
               out_load      = 1'b1;
               out_status_in = ST_DUMPED;
               out_key_in    = rd_data_ff;
               out_last_in   = dump_last;
               out_idx_in    = out_idx_ff + CW'(1);
            end
         end
         default: ;
      endcase
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         front_ff     <= '0;
         occ_ff       <= '0;
         rev_ff       <= 1'b0;
         data_vld_ff  <= 1'b0;
         rd_idx_ff    <= '0;
         out_idx_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         rev_ff       <= rev_in;
         data_vld_ff  <= data_vld_in;
         rd_idx_ff    <= rd_idx_in;
         out_idx_ff   <= out_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_key_ff    <= out_key_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) key_mem[wr_addr] <= cq_cmd.key;
      if (rd_en) rd_data_ff <= key_mem[rd_addr];
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_key_out = $signed(out_key_ff);
   assign rsp_last    = out_last_ff;
   assign occ_count   = occ_ff;

endmodule

[sv/deque_with_reverse.sv]
// Bounded double-ended queue of signed 32-bit keys held in a ring store of DEPTH
// entries. Each request carries a mode (push front, push back, pop front, pop back,
// reverse-and-dump) and a key. Requests pass through a decoder and a two-entry
// command queue into an execution engine, so the request side keeps moving until
// that queue fills while a result waits on rsp_ready. Push, pop front and every
// single-result failure (full_dropped, not_found, empty_list) finish as the engine
// takes the command. Pop back passes through BK_POP, since the key store has one
// registered read port. A dump takes the command, primes the registered store read
// and then streams the occupancy's worth of keys at one key per cycle while
// rsp_ready holds, through that same read port, front to back in the new order,
// with rsp_last on the final key. Reverse only flips which physical end is the
// logical front; no key moves. Undefined modes are taken and dropped without a
// result. The store has no reset; only held slots are read.
`include "assert_macros.svh"

module deque_with_reverse
   import dqr_pkg::*;
#(
   parameter int DEPTH = DQR_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic signed [KEY_W-1:0] req_key_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic signed [KEY_W-1:0] rsp_key_out,
   output logic                    rsp_last
);

   localparam int CW = $clog2(DEPTH + 1);

   // front end to command queue
   logic    cq_push, cq_full;
   cmd_type cq_push_cmd;

   // command queue to engine
   logic                cq_pop, cq_not_empty;
   cmd_type             cq_pop_cmd;
   logic [CQ_CNT_W-1:0] cq_count;

   logic [CW-1:0] occ_count;

   // decode the request and drop undefined modes
   dqr_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .req_key_in (req_key_in),
      .cq_push    (cq_push),
      .cq_cmd     (cq_push_cmd),
      .cq_full    (cq_full)
   );

   // hold decoded commands so either side can stall on its own
   dqr_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cq_push),
      .push_cmd  (cq_push_cmd),
      .full      (cq_full),
      .pop       (cq_pop),
      .pop_cmd   (cq_pop_cmd),
      .not_empty (cq_not_empty),
      .count     (cq_count)
   );

   // advance the ring pointers, read the store and drive the result register
   dqr_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cq_valid    (cq_not_empty),
      .cq_cmd      (cq_pop_cmd),
      .cq_pop      (cq_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_key_out (rsp_key_out),
      .rsp_last    (rsp_last),
      .occ_count   (occ_count)
   );

   `DQR_ASSERT_ALWAYS(a_occ_bound, clock, reset, occ_count <= CW'(DEPTH), "occupancy above depth")
   `DQR_ASSERT_ALWAYS(a_cq_bound, clock, reset,
      cq_count <= CQ_CNT_W'(CQ_DEPTH), "command queue overrun")
   `DQR_ASSERT_IMPLY(a_flag_result, clock, reset,
      rsp_valid && rsp_status != ST_DUMPED && rsp_status != ST_POPPED,
      rsp_key_out == 0 && rsp_last, "flag result with key or without last")

endmodule

[tb/tb_deque_with_reverse.sv]
// Self-checking testbench for the bounded deque with reverse-and-dump.
`timescale 1ns / 100ps

module tb_deque_with_reverse
   import dqr_pkg::*;
();

   localparam int DEPTH = DQR_DEPTH_DEF;

   // Modes the block takes and drops without a result
   localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;

   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

   // Random part ends once this many meaningful requests are planned
   localparam int RANDOM_OPS = 90;

   typedef struct {
      logic [MODE_W-1:0]       mode;
      logic signed [KEY_W-1:0] key;
   } req_item;

   typedef struct {
      status_type              status;
      logic signed [KEY_W-1:0] key;
      logic                    last;
   } rsp_item;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [MODE_W-1:0]       req_mode = '0;
   logic signed [KEY_W-1:0] req_key_in = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic signed [KEY_W-1:0] rsp_key_out;
   logic                    rsp_last;

   deque_with_reverse dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_key_in  (req_key_in),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_key_out (rsp_key_out),
      .rsp_last    (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow deque: ring of keys, physical head, count and reversed flag.
   // ------------------------------------------------------------------
   logic signed [KEY_W-1:0] ring_keys [DEPTH];
   int                      head_slot = 0;
   int                      key_count = 0;
   bit                      flipped = 1'b0;

   rsp_item                 expected_rsps [$];
   req_item                 pending_reqs [$];

   int unsigned cycle_no = 0;
   int          req_gap = 0;
   int          rsp_stall = 0;
   int          requests_taken = 0;
   int          rsps_checked = 0;
   int          mismatches = 0;
   int          full_drops = 0;
   int          peak_count = 0;
   int          dumps_done = 0;

   // Stimulus shaping only: a rough occupancy count of the planned requests
   int          plan_depth = 0;
   int          plan_ops = 0;

   function automatic void queue_rsp(status_type st, logic signed [KEY_W-1:0] k, logic fin);
      rsp_item item;
      item.status = st;
      item.key    = k;
      item.last   = fin;
      expected_rsps.push_back(item);
   endfunction

   // Apply one accepted request to the shadow deque and queue what it yields.
   function automatic void predict_request(logic [MODE_W-1:0] mode,
                                           logic signed [KEY_W-1:0] key);
      bit                      at_head;
      int                      pos;
      logic signed [KEY_W-1:0] taken;
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (key_count >= DEPTH) begin
               queue_rsp(ST_FULL, '0, 1'b1);
               full_drops++;
            end else begin
               // logical front sits at the physical head unless reversed
               at_head = (mode == MODE_PUSH_FRONT) != flipped;
               if (at_head) begin
                  head_slot = (head_slot + DEPTH - 1) % DEPTH;
                  ring_keys[head_slot] = key;
               end else begin
                  ring_keys[(head_slot + key_count) % DEPTH] = key;
               end
               key_count++;
               if (key_count > peak_count) peak_count = key_count;
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK: begin
            if (key_count == 0) begin
               queue_rsp(ST_NOT_FOUND, '0, 1'b1);
            end else begin
               at_head = (mode == MODE_POP_FRONT) != flipped;
               if (at_head) begin
                  taken = ring_keys[head_slot];
                  head_slot = (head_slot + 1) % DEPTH;
               end else begin
                  taken = ring_keys[(head_slot + key_count - 1) % DEPTH];
               end
               key_count--;
               if (mode == MODE_POP_BACK) queue_rsp(ST_POPPED, taken, 1'b1);
            end
         end
         MODE_DUMP: begin
            flipped = !flipped;
            dumps_done++;
            if (key_count == 0) begin
               queue_rsp(ST_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < key_count; i++) begin
                  pos = flipped ? key_count - 1 - i : i;
                  queue_rsp(ST_DUMPED, ring_keys[(head_slot + pos) % DEPTH],
                            i == key_count - 1);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic void plan_req(logic [MODE_W-1:0] mode, logic signed [KEY_W-1:0] key);
      req_item item;
      item.mode = mode;
      item.key  = key;
      pending_reqs.push_back(item);
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: if (plan_depth < DEPTH) plan_depth++;
         MODE_POP_FRONT, MODE_POP_BACK:   if (plan_depth > 0) plan_depth--;
         default: ;
      endcase
      if (mode <= MODE_DUMP) plan_ops++;
   endfunction

   function automatic logic signed [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0:       return KEY_MAX;
         1:       return KEY_MIN;
         2:       return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [MODE_W-1:0] pick_push();
      return $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
   endfunction

   function automatic logic [MODE_W-1:0] pick_pop();
      return $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
   endfunction

   // Gap length for either side: calm windows give none, otherwise mostly
   // short gaps with an occasional long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (cycle_no[8:7] == 2'b00) return 0;
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   always @(posedge clock) cycle_no <= cycle_no + 1;

   // ------------------------------------------------------------------
   // Request driver: hold a request until taken, then idle or advance.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      req_item next_req;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= pick_gap();
      end else if (req_valid && !req_ready) begin
         // hold the current request
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap   <= req_gap - 1;
      end else if (pending_reqs.size() != 0) begin
         next_req    = pending_reqs.pop_front();
         req_valid  <= 1'b1;
         req_mode   <= next_req.mode;
         req_key_in <= next_req.key;
         req_gap    <= pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result side back-pressure: stall for a random spell, then take again.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall <= pick_gap();
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each result against the oldest expectation, then
   // advance the shadow deque on each accepted request.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsps_checked++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: status %0d key %0d last %0b",
                           rsp_status, rsp_key_out, rsp_last);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status || rsp_key_out !== want.key ||
                   rsp_last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"result %0d: expected %s key %0d last %0b, ",
                               "got %0d key %0d last %0b"},
                              rsps_checked, want.status.name(), want.key, want.last,
                              rsp_status, rsp_key_out, rsp_last);
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_request(req_mode, req_key_in);
            requests_taken++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int total_reqs;
      int r;
      bit filled;
      filled = 1'b0;

      // Directed: every failure on an empty deque, dumps in both
      // orientations, reserved modes and extreme keys.
      plan_req(MODE_POP_FRONT, pick_key());
      plan_req(MODE_POP_BACK, pick_key());
      plan_req(MODE_DUMP, pick_key());      // empty dump, flips the order
      plan_req(MODE_DUMP, pick_key());      // and flips it back
      for (int m = MODE_RSVD_LO; m <= MODE_RSVD_HI; m++)
         plan_req(MODE_W'(m), pick_key());
      plan_req(MODE_PUSH_FRONT, KEY_MAX);
      plan_req(MODE_PUSH_BACK, KEY_MIN);
      plan_req(MODE_PUSH_FRONT, -32'sd1);
      plan_req(MODE_PUSH_BACK, 32'sd0);
      plan_req(MODE_PUSH_BACK, 32'sd1);
      plan_req(MODE_DUMP, '0);              // now reversed
      plan_req(MODE_POP_BACK, '0);
      plan_req(MODE_POP_FRONT, '0);
      plan_req(MODE_PUSH_FRONT, 32'sh5555_5555);
      plan_req(MODE_PUSH_BACK, 32'shAAAA_AAAA);
      plan_req(MODE_DUMP, '0);              // normal order again
      plan_req(MODE_POP_BACK, '0);
      plan_req(MODE_POP_FRONT, '0);
      plan_req(MODE_POP_BACK, '0);
      plan_req(MODE_POP_FRONT, '0);
      plan_req(MODE_POP_BACK, '0);
      plan_req(MODE_POP_FRONT, '0);         // empty again

      // Random: a mix of operations with one burst that fills the deque,
      // overflows it and partly drains it again.
      plan_ops = 0;
      while (plan_ops < RANDOM_OPS) begin
         if (!filled && plan_ops >= 20) begin
            filled = 1'b1;
            while (plan_depth < DEPTH) plan_req(pick_push(), pick_key());
            repeat ($urandom_range(2, 3)) plan_req(pick_push(), pick_key());
            plan_req(MODE_DUMP, '0);
            repeat ($urandom_range(15, 25)) plan_req(pick_pop(), '0);
            plan_req(MODE_DUMP, '0);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 8)
               plan_req(MODE_W'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI)), pick_key());
            else if (r < 18)
               plan_req(MODE_DUMP, pick_key());
            else if (r < 63)
               plan_req(pick_push(), pick_key());
            else
               plan_req(pick_pop(), pick_key());
         end
      end
      total_reqs = pending_reqs.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to go in and every result to come out,
      // then linger a little to catch stray results.
      while (requests_taken < total_reqs) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("%0d requests, %0d results checked, %0d dumps, %0d full drops",
               requests_taken, rsps_checked, dumps_done, full_drops);
      $display("peak occupancy %0d of %0d, %0d mismatches", peak_count, DEPTH, mismatches);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("tb_deque_with_reverse: clean");
      else
         $display("tb_deque_with_reverse: errors");
      $finish;
   end

   // Watchdog: far beyond a run where every result meets the longest stall
   initial begin
      #(10_000_000);
      $display("timeout with %0d results still expected", expected_rsps.size());
      $display("tb_deque_with_reverse: errors");
      $finish;
   end

endmodule
